@@ rtl/nfca_pkg.sv @@
`default_nettype none
package nfca_pkg;

  localparam int DEF_MAX_CORES = 64;
  localparam int DEF_MAX_SMT   = 4;

  localparam int OP_W    = 2;
  localparam int ID_W    = 8;
  localparam int CORES_W = 7;
  localparam int SMT_W   = 3;
  localparam int LOAD_W  = 8;
  localparam int ADDR_W  = 3;

  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

  localparam logic REG_CORES = 1'b0;
  localparam logic REG_SMT   = 1'b1;

  localparam logic [CORES_W-1:0] CORES_RESET = 7'd64;
  localparam logic [SMT_W-1:0]   SMT_RESET   = 3'd1;

  // scan kinds
  localparam logic [1:0] SCAN_CORE = 2'd0;  // nearest free core
  localparam logic [1:0] SCAN_FREE = 2'd1;  // nearest idle hyperthread
  localparam logic [1:0] SCAN_MIN  = 2'd2;  // least-loaded hyperthread

  typedef struct packed {
    logic       accept;
    logic       clr_step;
    logic       div_step;
    logic       scan_init;
    logic       scan_run;
    logic [1:0] scan_mode;
    logic       res_write;
    logic       claim;
    logic       prb_rd;
    logic       prb_chk;
    logic       bump;
    logic       load_out;
  } nfca_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            clr_last;
    logic            div_last;
    logic            scan_done;
    logic            got;
    logic            probe_hit;
  } nfca_sts_t;

endpackage
`default_nettype wire

@@ rtl/nfca_ctrl.sv @@
`default_nettype none
module nfca_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  input  wire logic [nfca_pkg::OP_W-1:0]   s_opcode,
  output logic                             s_tready,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output nfca_pkg::nfca_cmd_t              cmd,
  input  wire nfca_pkg::nfca_sts_t         sts
);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_CLR     = 4'd2;
  localparam logic [3:0] S_DIV     = 4'd3;
  localparam logic [3:0] S_RES     = 4'd4;
  localparam logic [3:0] S_SCAN1   = 4'd5;
  localparam logic [3:0] S_CLAIM   = 4'd6;
  localparam logic [3:0] S_PRB_RD  = 4'd7;
  localparam logic [3:0] S_PRB_CHK = 4'd8;
  localparam logic [3:0] S_SCAN2   = 4'd9;
  localparam logic [3:0] S_SCAN3   = 4'd10;
  localparam logic [3:0] S_BUMP    = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.scan_mode = nfca_pkg::SCAN_CORE;
    case (state)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          case (s_opcode)
            nfca_pkg::OP_CLEAR:   state_next = S_CLR;
            nfca_pkg::OP_RESERVE: state_next = S_DIV;
            nfca_pkg::OP_ALLOC:   state_next = S_DIV;
            default:              state_next = S_FIN;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          if (sts.op == nfca_pkg::OP_RESERVE) begin
            state_next = S_RES;
          end else begin
            cmd.scan_init = 1'b1;
            state_next = S_SCAN1;
          end
        end
      end
      S_RES: begin
        cmd.res_write = 1'b1;
        state_next = S_FIN;
      end
      S_SCAN1: begin
        cmd.scan_run = 1'b1;
        cmd.scan_mode = nfca_pkg::SCAN_CORE;
        if (sts.scan_done) begin
          if (sts.got) begin
            state_next = S_CLAIM;
          end else begin
            cmd.scan_init = 1'b1;
            state_next = S_SCAN2;
          end
        end
      end
      S_CLAIM: begin
        cmd.claim = 1'b1;
        state_next = S_PRB_RD;
      end
      S_PRB_RD: begin
        cmd.prb_rd = 1'b1;
        state_next = S_PRB_CHK;
      end
      S_PRB_CHK: begin
        cmd.prb_chk = 1'b1;
        state_next = sts.probe_hit ? S_BUMP : S_PRB_RD;
      end
      S_SCAN2: begin
        cmd.scan_run = 1'b1;
        cmd.scan_mode = nfca_pkg::SCAN_FREE;
        if (sts.scan_done) begin
          if (sts.got) begin
            state_next = S_BUMP;
          end else begin
            cmd.scan_init = 1'b1;
            state_next = S_SCAN3;
          end
        end
      end
      S_SCAN3: begin
        cmd.scan_run = 1'b1;
        cmd.scan_mode = nfca_pkg::SCAN_MIN;
        if (sts.scan_done) state_next = S_BUMP;
      end
      S_BUMP: begin
        cmd.bump = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/nfca_dp.sv @@
`default_nettype none
module nfca_dp #(
  parameter int MAX_CORES = nfca_pkg::DEF_MAX_CORES,
  parameter int MAX_SMT   = nfca_pkg::DEF_MAX_SMT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [nfca_pkg::ID_W-1:0]      base_in,
  input  wire logic [nfca_pkg::OP_W-1:0]      op_in,
  input  wire logic [nfca_pkg::CORES_W-1:0]   cores_in_use,
  input  wire logic [nfca_pkg::SMT_W-1:0]     threads_per_core,
  input  wire nfca_pkg::nfca_cmd_t            cmd,
  output nfca_pkg::nfca_sts_t                 sts,
  output logic [nfca_pkg::ID_W-1:0]           m_tdata,
  output logic [0:0]                          m_tuser
);

  localparam int MAX_HW = MAX_CORES * MAX_SMT;
  localparam int HW_AW  = (MAX_HW > 1) ? $clog2(MAX_HW) : 1;
  localparam int HW_CW  = $clog2(MAX_HW + 1);
  localparam int CA_W   = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int CW     = nfca_pkg::CORES_W;
  localparam int TW     = nfca_pkg::SMT_W;
  localparam int LW     = nfca_pkg::LOAD_W;
  localparam int IW     = nfca_pkg::ID_W;

  logic          core_mem [MAX_CORES];
  logic [LW-1:0] load_mem [MAX_HW];
  logic          core_rd;
  logic [LW-1:0] load_rd;

  logic [nfca_pkg::OP_W-1:0] op;
  logic [IW-1:0]    base;
  logic [CW-1:0]    c_eff;
  logic [TW-1:0]    t_eff;
  logic [HW_CW-1:0] nhw;
  logic             in_range;

  // home core = base mod C, one quotient bit per step
  logic [7:0] rem;
  logic [2:0] dcnt;
  logic [7:0] trial;

  logic [HW_AW-1:0] clr_cnt;

  logic [HW_CW-1:0] idx;
  logic [HW_CW-1:0] idx_q;
  logic [HW_CW-1:0] limit;
  logic [CW-1:0]    qc;
  logic [CW-1:0]    qc_q;
  logic             vld_q;
  logic [8:0]       bd;
  logic             got;
  logic [CA_W-1:0]  best_c;
  logic [HW_AW-1:0] best_h;
  logic [LW-1:0]    best_load;
  logic [7:0]       qv;
  logic [7:0]       delta;

  logic [HW_AW-1:0] paddr;
  logic [TW-1:0]    p;
  logic             hit;

  logic             core_we;
  logic [CA_W-1:0]  core_wa;
  logic             core_wd;
  logic             load_we;
  logic [HW_AW-1:0] load_wa;
  logic [LW-1:0]    load_wd;
  logic [HW_AW-1:0] load_ra;

  logic [IW-1:0]    res_thread;
  logic             res_found;

  always_comb begin
    if (cores_in_use == '0) c_eff = CW'(1);
    else if (int'(cores_in_use) > MAX_CORES) c_eff = CW'(MAX_CORES);
    else c_eff = cores_in_use;
    if (threads_per_core == '0) t_eff = TW'(1);
    else if (int'(threads_per_core) > MAX_SMT) t_eff = TW'(MAX_SMT);
    else t_eff = threads_per_core;
  end

  assign nhw      = HW_CW'(int'(c_eff) * int'(t_eff));
  assign in_range = int'(base) < int'(nhw);

  always_comb begin
    trial = {rem[6:0], base[3'd7 - dcnt]};
    if (trial >= {1'b0, c_eff}) trial = trial - {1'b0, c_eff};
  end

  assign limit = (cmd.scan_mode == nfca_pkg::SCAN_CORE) ? HW_CW'(c_eff) : nhw;
  assign qv    = (cmd.scan_mode == nfca_pkg::SCAN_CORE) ? 8'(idx_q) : 8'(qc_q);
  assign delta = (rem > qv) ? (rem - qv) : (qv - rem);
  assign hit   = (load_rd == '0) || (p == t_eff - TW'(1));

  assign sts.op        = op;
  assign sts.clr_last  = (clr_cnt == HW_AW'(MAX_HW - 1));
  assign sts.div_last  = (dcnt == 3'd7);
  assign sts.scan_done = (idx == limit) && !vld_q;
  assign sts.got       = got;
  assign sts.probe_hit = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= sts.clr_last ? '0 : clr_cnt + HW_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op   <= op_in;
      base <= base_in;
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= trial;
      dcnt <= dcnt + 3'd1;
    end
  end

  // scan: issue a read at idx, judge the entry in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      idx   <= '0;
      qc    <= '0;
      vld_q <= 1'b0;
      bd    <= '1;
      got   <= 1'b0;
    end else if (cmd.scan_run) begin
      if (idx != limit) begin
        vld_q <= 1'b1;
        idx_q <= idx;
        qc_q  <= qc;
        idx   <= idx + HW_CW'(1);
        qc    <= (qc == c_eff - CW'(1)) ? '0 : qc + CW'(1);
      end else begin
        vld_q <= 1'b0;
      end
      if (vld_q) begin
        case (cmd.scan_mode)
          nfca_pkg::SCAN_CORE: begin
            if (!core_rd && ({1'b0, delta} <= bd)) begin
              bd     <= {1'b0, delta};
              best_c <= CA_W'(idx_q);
              got    <= 1'b1;
            end
          end
          nfca_pkg::SCAN_FREE: begin
            if ((load_rd == '0) && ({1'b0, delta} <= bd)) begin
              bd        <= {1'b0, delta};
              best_h    <= HW_AW'(idx_q);
              best_load <= '0;
              got       <= 1'b1;
            end
          end
          nfca_pkg::SCAN_MIN: begin
            if ({1'b0, load_rd} <= bd) begin
              bd        <= {1'b0, load_rd};
              best_h    <= HW_AW'(idx_q);
              best_load <= load_rd;
            end
          end
          default: ;
        endcase
      end
    end else if (cmd.claim) begin
      paddr <= HW_AW'(best_c);
      p     <= '0;
    end else if (cmd.prb_chk) begin
      if (hit) begin
        best_h    <= paddr;
        best_load <= load_rd;
      end else begin
        paddr <= paddr + HW_AW'(c_eff);
        p     <= p + TW'(1);
      end
    end
  end

  always_comb begin
    core_we = 1'b0;
    core_wa = best_c;
    core_wd = 1'b1;
    if (cmd.clr_step) begin
      core_we = int'(clr_cnt) < MAX_CORES;
      core_wa = CA_W'(clr_cnt);
      core_wd = 1'b0;
    end else if (cmd.res_write) begin
      core_we = in_range;
      core_wa = CA_W'(rem);
    end else if (cmd.claim) begin
      core_we = 1'b1;
    end
  end

  always_comb begin
    load_we = 1'b0;
    load_wa = best_h;
    load_wd = (best_load == '1) ? best_load : best_load + LW'(1);
    if (cmd.clr_step) begin
      load_we = 1'b1;
      load_wa = clr_cnt;
      load_wd = '0;
    end else if (cmd.res_write) begin
      load_we = in_range;
      load_wa = HW_AW'(base);
      load_wd = LW'(1);
    end else if (cmd.bump) begin
      load_we = 1'b1;
    end
  end

  assign load_ra = cmd.prb_rd ? paddr : HW_AW'(idx);

  always_ff @(posedge clk) begin
    if (core_we) core_mem[core_wa] <= core_wd;
    core_rd <= core_mem[CA_W'(idx)];
  end

  always_ff @(posedge clk) begin
    if (load_we) load_mem[load_wa] <= load_wd;
    load_rd <= load_mem[load_ra];
  end

  always_comb begin
    case (op)
      nfca_pkg::OP_CLEAR: begin
        res_thread = '0;
        res_found  = 1'b1;
      end
      nfca_pkg::OP_RESERVE: begin
        res_thread = base;
        res_found  = in_range;
      end
      nfca_pkg::OP_ALLOC: begin
        res_thread = IW'(best_h);
        res_found  = 1'b1;
      end
      default: begin
        res_thread = '0;
        res_found  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= res_thread;
      m_tuser <= res_found;
    end
  end

endmodule
`default_nettype wire

@@ rtl/nearest_free_core_allocator.sv @@
// nearest_free_core_allocator: places software threads onto hardware threads.
// slave stream: s_tuser = opcode (clear, reserve, allocate, no-op),
//   s_tdata = base hardware thread id. master stream: m_tdata = chosen or
//   echoed thread id, m_tuser = found flag. apb port: cores_in_use at 0x0,
//   threads_per_core at 0x4, written by the user only while the block is idle;
//   the block itself does not enforce this.
// one transaction at a time; the next input is taken once the result sits in
// the output register, so a stalled receiver holds only that one result.
// an allocate finds the home core with the bit-serial remainder (8 steps), then
// scans the busy bits for the nearest free core; if one is found it claims it
// and probes that core's hyperthreads, up to threads_per_core probes, for an
// idle or its last one; else it scans the loads for the nearest idle, and then
// the least-loaded, hyperthread. the scans read one busy bit or load count per
// cycle from a memory with one read port.
// after reset the load and busy memories are swept to zero, one entry per
// cycle through all MAX_CORES*MAX_SMT entries, with s_tready low; config
// writes are still taken.
`default_nettype none
module nearest_free_core_allocator #(
  parameter int MAX_CORES = nfca_pkg::DEF_MAX_CORES,
  parameter int MAX_SMT   = nfca_pkg::DEF_MAX_SMT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [nfca_pkg::ID_W-1:0]     s_tdata,   // [7:0] base_id
  input  wire logic [nfca_pkg::OP_W-1:0]     s_tuser,   // [1:0] opcode
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [nfca_pkg::ID_W-1:0]          m_tdata,   // [7:0] assigned_thread
  output logic [0:0]                         m_tuser,   // [0] found
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nfca_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [nfca_pkg::CORES_W-1:0] cores_in_use;
  logic [nfca_pkg::SMT_W-1:0]   threads_per_core;
  logic                         wr_en;
  nfca_pkg::nfca_cmd_t          cmd;
  nfca_pkg::nfca_sts_t          sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cores_in_use     <= nfca_pkg::CORES_RESET;
      threads_per_core <= nfca_pkg::SMT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        nfca_pkg::REG_CORES: cores_in_use <= pwdata[nfca_pkg::CORES_W-1:0];
        nfca_pkg::REG_SMT:   threads_per_core <= pwdata[nfca_pkg::SMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      nfca_pkg::REG_CORES: prdata = 32'(cores_in_use);
      nfca_pkg::REG_SMT:   prdata = 32'(threads_per_core);
      default:             prdata = '0;
    endcase
  end

  nfca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_opcode (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  nfca_dp #(
    .MAX_CORES (MAX_CORES),
    .MAX_SMT   (MAX_SMT)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .base_in          (s_tdata),
    .op_in            (s_tuser),
    .cores_in_use     (cores_in_use),
    .threads_per_core (threads_per_core),
    .cmd              (cmd),
    .sts              (sts),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser)
  );

  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while full");

  // datapath operations never overlap
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_step, cmd.div_step, cmd.scan_run, cmd.res_write,
              cmd.claim, cmd.prb_rd, cmd.prb_chk, cmd.bump, cmd.load_out}))
    else $error("overlapping datapath operations");

  // one item in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !s_tready)
    else $error("second transaction taken while busy");

endmodule
`default_nettype wire
